/* rtl/rbrc_pkg.sv */
// ----------------------------------------------------------------------------
// rbrc_pkg
// shared types, codes and time helpers for the retry backoff controller
// ----------------------------------------------------------------------------
package rbrc_pkg;

  localparam int TIME_W      = 32;
  localparam int CNT_W       = 4;
  localparam int EXP_PAD     = 15;  // covers the largest backoff exponent of a 4-bit count
  localparam logic [CNT_W-1:0] MAX_ATTEMPT_LIMIT = CNT_W'(8);

  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [1:0] {
    REG_INITIAL_DELAY = 2'd0,
    REG_FIRST_RETRY   = 2'd1,
    REG_MAX_RETRY     = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    CMD_BEGIN    = 3'd0,
    CMD_TRY      = 3'd1,
    CMD_COMPLETE = 3'd2,
    CMD_ABANDON  = 3'd3,
    CMD_RESET    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    OUT_NONE      = 3'd0,
    OUT_INACTIVE  = 3'd1,
    OUT_BLOCKED   = 3'd2,
    OUT_EXHAUSTED = 3'd3,
    OUT_DEFERRED  = 3'd4,
    OUT_STARTED   = 3'd5
  } outcome_e;

  typedef struct packed {
    logic [2:0]        command;
    logic [TIME_W-1:0] now_ticks;
    logic              now_valid;
    logic [CNT_W-1:0]  attempt_budget;
    logic              app_active;
    logic              policy_allows;
    logic              recovered;
  } item_t;

  typedef struct packed {
    outcome_e          outcome;
    logic [TIME_W-1:0] retry_delay_ticks;
    logic [CNT_W-1:0]  attempt_number;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] initial_delay;
    logic [TIME_W-1:0] first_retry_delay;
    logic [TIME_W-1:0] max_retry_delay;
  } cfg_t;

  typedef struct packed {
    logic             recovering;
    logic             in_flight;
    logic [CNT_W-1:0] attempt_count;
    logic [CNT_W-1:0] attempt_limit;
  } status_t;

  // saturating add on time values
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  // min(base << max(0, count-1), cap) with the shift saturating
  function automatic logic [TIME_W-1:0] backoff(input logic [TIME_W-1:0] base,
                                                input logic [TIME_W-1:0] cap,
                                                input logic [CNT_W-1:0]  count);
    logic [CNT_W-1:0]          e;
    logic [TIME_W+EXP_PAD-1:0] wide;
    logic [TIME_W-1:0]         d;
    e    = (count == '0) ? '0 : count - CNT_W'(1);
    wide = {{EXP_PAD{1'b0}}, base} << e;
    d    = (|wide[TIME_W+EXP_PAD-1:TIME_W]) ? {TIME_W{1'b1}} : wide[TIME_W-1:0];
    return (d < cap) ? d : cap;
  endfunction

endpackage

/* rtl/rbrc_cfg.sv */
// ----------------------------------------------------------------------------
// rbrc_cfg
// apb-style register file holding the three delay settings
// ----------------------------------------------------------------------------
module rbrc_cfg
  import rbrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [TIME_W-1:0] init_r, first_r, max_r;
  logic              wr_en;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r  <= '0;
      first_r <= '0;
      max_r   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_INITIAL_DELAY: init_r  <= pwdata;
        REG_FIRST_RETRY:   first_r <= pwdata;
        REG_MAX_RETRY:     max_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INITIAL_DELAY: prdata = init_r;
      REG_FIRST_RETRY:   prdata = first_r;
      REG_MAX_RETRY:     prdata = max_r;
      default:           prdata = '0;
    endcase
  end

  assign cfg = '{initial_delay: init_r, first_retry_delay: first_r, max_retry_delay: max_r};

endmodule

/* rtl/rbrc_core.sv */
// ----------------------------------------------------------------------------
// rbrc_core
// recovery state and per-command decision logic
// ----------------------------------------------------------------------------
module rbrc_core
  import rbrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res,
  output status_t stat
);

  logic              rec_r, rec_nxt;
  logic              exh_r, exh_nxt;
  logic              fly_r, fly_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  lim_r, lim_nxt;
  logic [TIME_W-1:0] nat_r, nat_nxt;

  logic [TIME_W-1:0] t0;
  logic [TIME_W-1:0] t_try;
  logic              spent;
  cmd_e              cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= 1'b0;
      exh_r <= 1'b0;
      fly_r <= 1'b0;
      cnt_r <= '0;
      lim_r <= '0;
      nat_r <= '0;
    end else if (fire) begin
      rec_r <= rec_nxt;
      exh_r <= exh_nxt;
      fly_r <= fly_nxt;
      cnt_r <= cnt_nxt;
      lim_r <= lim_nxt;
      nat_r <= nat_nxt;
    end
  end

  assign cmd   = cmd_e'(item.command);
  assign t0    = item.now_valid ? item.now_ticks : '0;
  assign t_try = item.now_valid ? item.now_ticks : nat_r;
  assign spent = exh_r | (cnt_r >= lim_r);

  always_comb begin
    rec_nxt = rec_r;
    exh_nxt = exh_r;
    fly_nxt = fly_r;
    cnt_nxt = cnt_r;
    lim_nxt = lim_r;
    nat_nxt = nat_r;
    res     = '{outcome: OUT_NONE, retry_delay_ticks: '0, attempt_number: '0};

    unique case (cmd)
      CMD_BEGIN: begin
        if (!rec_r) begin
          rec_nxt = 1'b1;
          exh_nxt = (item.attempt_budget == '0);
          fly_nxt = 1'b0;
          cnt_nxt = '0;
          lim_nxt = (item.attempt_budget > MAX_ATTEMPT_LIMIT) ? MAX_ATTEMPT_LIMIT
                                                              : item.attempt_budget;
          nat_nxt = sat_add(t0, cfg.initial_delay);
        end
      end
      CMD_TRY: begin
        priority if (!rec_r) begin
          res.outcome = OUT_NONE;
        end else if (!item.app_active) begin
          res.outcome = OUT_INACTIVE;
        end else if (!item.policy_allows) begin
          res.outcome = OUT_BLOCKED;
        end else if (spent) begin
          exh_nxt     = 1'b1;
          res.outcome = OUT_EXHAUSTED;
        end else if (fly_r) begin
          res.outcome = OUT_DEFERRED;
        end else if (t_try < nat_r) begin
          res.outcome           = OUT_DEFERRED;
          res.retry_delay_ticks = nat_r - t_try;
        end else begin
          fly_nxt            = 1'b1;
          cnt_nxt            = cnt_r + CNT_W'(1);
          res.outcome        = OUT_STARTED;
          res.attempt_number = cnt_r + CNT_W'(1);
        end
      end
      CMD_COMPLETE: begin
        if (rec_r && fly_r) begin
          fly_nxt = 1'b0;
          priority if (item.recovered) begin
            rec_nxt = 1'b0;
            exh_nxt = 1'b0;
            cnt_nxt = '0;
            lim_nxt = '0;
            nat_nxt = '0;
          end else if (cnt_r >= lim_r) begin
            exh_nxt = 1'b1;
          end else begin
            nat_nxt = sat_add(t0, backoff(cfg.first_retry_delay, cfg.max_retry_delay,
                                          cnt_r));
          end
        end
      end
      CMD_ABANDON: begin
        if (rec_r) begin
          fly_nxt = 1'b0;
          exh_nxt = 1'b1;
        end
      end
      CMD_RESET: begin
        rec_nxt = 1'b0;
        exh_nxt = 1'b0;
        fly_nxt = 1'b0;
        cnt_nxt = '0;
        lim_nxt = '0;
        nat_nxt = '0;
      end
      default: ;
    endcase
  end

  assign stat = '{recovering: rec_r, in_flight: fly_r, attempt_count: cnt_r,
                  attempt_limit: lim_r};

endmodule

/* rtl/retry_backoff_recovery_controller.sv */
// ----------------------------------------------------------------------------
// retry_backoff_recovery_controller
// recovery retry controller with exponential backoff, one result per command
// ----------------------------------------------------------------------------
//
//   channel   ports      direction   transfer when
//   --------  ---------  ----------  ---------------------------------
//   command   in_*       input       in_valid high, in_stall low
//   result    out_*      output      out_valid high, out_stall low
//   config    cfg_p*     input       cfg_psel, cfg_penable, cfg_pwrite
//
// one command per cycle sustained while out_stall is low; the result reaches
// out_* through the input register and the result register around the single
// decision stage
// the decision stage updates the recovery state as the command moves into the
// result register, so consecutive commands see each other's effect
// a stalled result holds; the input register takes a new command when it is
// empty or when its command moves into the result register in the same cycle
// synchronous active-low reset clears state, delay registers and valid flags
//
module retry_backoff_recovery_controller
  import rbrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  // command channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_command,
  input  logic [TIME_W-1:0]     in_now_ticks,
  input  logic                  in_now_valid,
  input  logic [CNT_W-1:0]      in_attempt_budget,
  input  logic                  in_app_active,
  input  logic                  in_policy_allows,
  input  logic                  in_recovered,

  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_outcome,
  output logic [TIME_W-1:0]     out_retry_delay_ticks,
  output logic [CNT_W-1:0]      out_attempt_number,

  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t    cfg;
  status_t stat;
  result_t res;

  // input register
  logic    in_vld_r, in_vld_nxt;
  item_t   item_r;
  logic    in_take;

  // result register
  logic    out_vld_r, out_vld_nxt;
  result_t out_res_r;

  // command moves from the input register through the decision stage
  logic    adv;

  rbrc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rbrc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res),
    .stat  (stat)
  );

  // result register frees up when empty or when its transfer completes now
  assign adv      = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~adv;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= '{command:        in_command,
                  now_ticks:      in_now_ticks,
                  now_valid:      in_now_valid,
                  attempt_budget: in_attempt_budget,
                  app_active:     in_app_active,
                  policy_allows:  in_policy_allows,
                  recovered:      in_recovered};
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_outcome           = out_res_r.outcome;
  assign out_retry_delay_ticks = out_res_r.retry_delay_ticks;
  assign out_attempt_number    = out_res_r.attempt_number;

  // an attempt can only be in flight during a recovery
  a_flight_needs_recovery: assert property (@(posedge clk) disable iff (!rst_n)
    stat.in_flight |-> stat.recovering)
    else $error("attempt in flight outside recovery");

  // the attempt count never passes the limit taken at begin
  a_count_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.attempt_count <= stat.attempt_limit) && (stat.attempt_limit <= MAX_ATTEMPT_LIMIT))
    else $error("attempt count beyond limit");

  // a started attempt leaves an attempt in flight with the reported number
  a_start_sets_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.outcome == OUT_STARTED) |=>
      (stat.in_flight && stat.attempt_count == out_res_r.attempt_number))
    else $error("started attempt not recorded");

  // a remaining wait is reported only with a deferred outcome
  a_delay_only_deferred: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.outcome != OUT_DEFERRED) |-> (out_res_r.retry_delay_ticks == '0))
    else $error("delay reported without deferral");

endmodule
